// File: sv/tx_record_stream_parser_top_assert.svh
// Assertion macros shared by the record stream parser RTL.
`ifndef TX_RECORD_STREAM_PARSER_TOP_ASSERT_SVH
`define TX_RECORD_STREAM_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, checked on clk, disabled while arst_n is low.
`define TRSP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, disabled while arst_n is low.
`define TRSP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/trsp_pkg.sv
// Types and constants for the transaction record stream parser.
package trsp_pkg;

	localparam int COUNT_W = 32;

	localparam logic [5:0] TXID_LEN  = 6'd32;
	localparam logic [5:0] VALUE_LEN = 6'd8;
	localparam logic [5:0] WORD_LEN  = 6'd4;

	localparam logic [7:0] PFX_U16 = 8'hFD;
	localparam logic [7:0] PFX_U32 = 8'hFE;

	localparam logic [3:0] VAR_LEN_U16 = 4'd2;
	localparam logic [3:0] VAR_LEN_U32 = 4'd4;
	localparam logic [3:0] VAR_LEN_U64 = 4'd8;

	typedef enum logic [3:0] {
		K_VER    = 4'd0,
		K_INCNT  = 4'd1,
		K_TXID   = 4'd2,
		K_OUTIDX = 4'd3,
		K_INSLEN = 4'd4,
		K_INSCR  = 4'd5,
		K_SEQ    = 4'd6,
		K_OUTCNT = 4'd7,
		K_VALUE  = 4'd8,
		K_OUTSLEN = 4'd9,
		K_OUTSCR = 4'd10,
		K_LOCK   = 4'd11
	} kind_t;

	typedef struct packed {
		logic [7:0]  byte_out;
		kind_t       field_kind;
		logic [31:0] byte_position;
		logic [31:0] entry_index;
		logic        field_done;
		logic [63:0] field_value;
		logic        tx_done;
		logic        overflow;
	} result_t;

endpackage

// File: sv/trsp_if.sv
// Handshake channels of the record stream parser: raw bytes in, tagged bytes out.
interface trsp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       restart;

	modport source (output valid, output data_byte, output restart, input ready);
	modport sink (input valid, input data_byte, input restart, output ready);
endinterface

interface trsp_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  byte_out;
	logic [3:0]  field_kind;
	logic [31:0] byte_position;
	logic [31:0] entry_index;
	logic        field_done;
	logic [63:0] field_value;
	logic        tx_done;
	logic        overflow;

	modport source (output valid, output byte_out, output field_kind, output byte_position,
		output entry_index, output field_done, output field_value, output tx_done,
		output overflow, input ready);
	modport sink (input valid, input byte_out, input field_kind, input byte_position,
		input entry_index, input field_done, input field_value, input tx_done,
		input overflow, output ready);
endinterface

// File: sv/trsp_core.sv
// Parse state and single-byte step logic of the record stream parser.
module trsp_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic [7:0]        data_byte,
	input  logic              restart,
	output trsp_pkg::result_t res
);
	import trsp_pkg::*;

	kind_t              phase_q;
	logic [31:0]        off_q;
	logic [63:0]        acc_q;
	logic [3:0]         vleft_q;
	logic [COUNT_W-1:0] eleft_q;
	logic [COUNT_W-1:0] enum_q;
	logic [COUNT_W-1:0] sleft_q;

	kind_t              p;
	logic [31:0]        off;
	logic [63:0]        acc;
	logic [3:0]         vl;
	logic [COUNT_W-1:0] el;
	logic [COUNT_W-1:0] en;
	logic [COUNT_W-1:0] sl;

	kind_t              nphase;
	logic [31:0]        noff;
	logic [63:0]        nacc;
	logic [3:0]         nvl;
	logic [COUNT_W-1:0] nel;
	logic [COUNT_W-1:0] nen;
	logic [COUNT_W-1:0] nsl;

	logic               go_en;
	kind_t              go;
	logic               ee;
	kind_t              ee_next;
	kind_t              ee_last;
	logic               clr;
	logic [5:0]         len;
	logic [63:0]        v;
	logic               complete;
	logic [COUNT_W-1:0] c;
	logic [COUNT_W-1:0] el_d;
	logic [3:0]         vl_d;
	logic [COUNT_W-1:0] sl_d;
	logic [63:0]        en64;
	logic [31:0]        offm1;

	always_comb begin
		// a restart byte or a meaningless phase code starts from the reset state
		if (restart || phase_q > K_LOCK) begin
			p   = K_VER;
			off = '0;
			acc = '0;
			vl  = '0;
			el  = '0;
			en  = '0;
			sl  = '0;
		end else begin
			p   = phase_q;
			off = off_q;
			acc = acc_q;
			vl  = vleft_q;
			el  = eleft_q;
			en  = enum_q;
			sl  = sleft_q;
		end

		nphase   = p;
		noff     = off;
		nacc     = acc;
		nvl      = vl;
		nel      = el;
		nen      = en;
		nsl      = sl;
		go_en    = 1'b0;
		go       = p;
		ee       = 1'b0;
		ee_next  = K_VALUE;
		ee_last  = K_LOCK;
		clr      = 1'b0;
		v        = '0;
		complete = 1'b0;
		c        = '0;
		el_d     = '0;
		vl_d     = '0;
		sl_d     = '0;
		offm1    = off - 32'd1;
		en64     = 64'(en);
		len      = WORD_LEN;

		res.byte_out      = data_byte;
		res.field_kind    = p;
		res.byte_position = off;
		res.entry_index   = '0;
		res.field_done    = 1'b0;
		res.field_value   = '0;
		res.tx_done       = 1'b0;
		res.overflow      = 1'b0;

		if (p inside {[K_TXID:K_SEQ], [K_VALUE:K_OUTSCR]})
			res.entry_index = en64[31:0];

		case (p)
			K_VER, K_TXID, K_OUTIDX, K_SEQ, K_VALUE, K_LOCK: begin
				if (p == K_TXID)
					len = TXID_LEN;
				else if (p == K_VALUE)
					len = VALUE_LEN;
				if (off < 32'd8)
					nacc = acc | (64'(data_byte) << {off[2:0], 3'b000});
				noff = off + 32'd1;
				if (noff >= 32'(len)) begin
					res.field_done  = 1'b1;
					res.field_value = (p == K_TXID) ? '0 : nacc;
					go_en = 1'b1;
					case (p)
						K_VER:    go = K_INCNT;
						K_TXID:   go = K_OUTIDX;
						K_OUTIDX: go = K_INSLEN;
						K_SEQ: begin
							go_en   = 1'b0;
							ee      = 1'b1;
							ee_next = K_TXID;
							ee_last = K_OUTCNT;
						end
						K_VALUE:  go = K_OUTSLEN;
						default: begin
							go_en       = 1'b0;
							res.tx_done = 1'b1;
							clr         = 1'b1;
						end
					endcase
				end
			end
			K_INCNT, K_INSLEN, K_OUTCNT, K_OUTSLEN: begin
				if (off == '0) begin
					if (data_byte < PFX_U16) begin
						v        = 64'(data_byte);
						complete = 1'b1;
					end else begin
						nvl  = (data_byte == PFX_U16) ? VAR_LEN_U16 :
							(data_byte == PFX_U32) ? VAR_LEN_U32 : VAR_LEN_U64;
						nacc = '0;
						noff = 32'd1;
					end
				end else begin
					nacc = acc | (64'(data_byte) << {offm1[2:0], 3'b000});
					noff = off + 32'd1;
					vl_d = (vl != '0) ? vl - 4'd1 : vl;
					nvl  = vl_d;
					if (vl_d == '0) begin
						v        = nacc;
						complete = 1'b1;
					end
				end
				if (complete) begin
					res.field_done  = 1'b1;
					res.field_value = v;
					// saturate counts that do not fit the counters
					res.overflow    = (v >> COUNT_W) != '0;
					c = res.overflow ? '1 : v[COUNT_W-1:0];
					go_en = 1'b1;
					case (p)
						K_INCNT: begin
							if (c == '0) begin
								go = K_OUTCNT;
							end else begin
								nel = c;
								nen = '0;
								go  = K_TXID;
							end
						end
						K_INSLEN: begin
							if (c == '0) begin
								go = K_SEQ;
							end else begin
								nsl = c;
								go  = K_INSCR;
							end
						end
						K_OUTCNT: begin
							if (c == '0) begin
								go = K_LOCK;
							end else begin
								nel = c;
								nen = '0;
								go  = K_VALUE;
							end
						end
						default: begin
							if (c == '0) begin
								go_en = 1'b0;
								ee    = 1'b1;
							end else begin
								nsl = c;
								go  = K_OUTSCR;
							end
						end
					endcase
				end
			end
			default: begin
				noff = off + 32'd1;
				sl_d = (sl != '0) ? sl - COUNT_W'(1) : sl;
				nsl  = sl_d;
				if (sl_d == '0) begin
					res.field_done = 1'b1;
					if (p == K_INSCR) begin
						go_en = 1'b1;
						go    = K_SEQ;
					end else begin
						ee = 1'b1;
					end
				end
			end
		endcase

		// close one input or output entry
		if (ee) begin
			el_d  = (el != '0) ? el - COUNT_W'(1) : el;
			nel   = el_d;
			nen   = en + COUNT_W'(1);
			go_en = 1'b1;
			if (el_d == '0) begin
				nen = '0;
				go  = ee_last;
			end else begin
				go  = ee_next;
			end
		end

		if (go_en) begin
			nphase = go;
			noff   = '0;
			nacc   = '0;
			nvl    = '0;
		end

		if (clr) begin
			nphase = K_VER;
			noff   = '0;
			nacc   = '0;
			nvl    = '0;
			nel    = '0;
			nen    = '0;
			nsl    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= K_VER;
			off_q   <= '0;
			acc_q   <= '0;
			vleft_q <= '0;
			eleft_q <= '0;
			enum_q  <= '0;
			sleft_q <= '0;
		end else if (advance) begin
			phase_q <= nphase;
			off_q   <= noff;
			acc_q   <= nacc;
			vleft_q <= nvl;
			eleft_q <= nel;
			enum_q  <= nen;
			sleft_q <= nsl;
		end
	end

endmodule

// File: sv/tx_record_stream_parser_top.sv
// Top level of the transaction record stream parser: byte tagging with handshakes.
//
// Usage:
//   stream carries one raw transaction byte per item (data_byte), with restart
//   set on a byte that begins a new transaction regardless of the parse state.
//   result carries one item per input byte: the byte, its field kind, offset in
//   the field or script, input/output entry index, field completion flag, the
//   little-endian value of a completed numeric field, end-of-transaction flag
//   and an overflow flag for counts or lengths beyond the counter width.
//   An accepted byte is registered in the input stage, stepped into the result
//   stage once that stage is free, and is offered on result from then on.
//   Throughput: one byte per cycle while the receiver takes results, set by the
//   combinational step that updates the parse state between the two registers.
//   Reset (arst_n low) empties both stages and returns the parser to the
//   version field with all counters cleared.
//   When the receiver stalls the result stage holds its item, the input stage
//   fills behind it, and stream.ready then drops until the receiver takes the
//   waiting item; nothing is lost or repeated.
`include "tx_record_stream_parser_top_assert.svh"

module tx_record_stream_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	trsp_in_if.sink     stream,
	trsp_out_if.source  result
);
	import trsp_pkg::*;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       restart_s1;
	logic       valid_s2;
	result_t    res_s2;
	result_t    step_res;
	logic       s2_free;
	logic       adv;

	// advance the input stage whenever the result stage is empty or draining
	assign s2_free      = !valid_s2 || result.ready;
	assign adv          = valid_s1 && s2_free;
	assign stream.ready = !valid_s1 || adv;

	trsp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (adv),
		.data_byte (data_s1),
		.restart   (restart_s1),
		.res       (step_res)
	);

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (stream.valid && stream.ready)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv)
				valid_s2 <= 1'b1;
			else if (result.ready)
				valid_s2 <= 1'b0;
		end
	end

	// payload: load the input stage on accept, hold the result while stalled
	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			data_s1    <= stream.data_byte;
			restart_s1 <= stream.restart;
		end
		if (adv)
			res_s2 <= step_res;
	end

	assign result.valid         = valid_s2;
	assign result.byte_out      = res_s2.byte_out;
	assign result.field_kind    = res_s2.field_kind;
	assign result.byte_position = res_s2.byte_position;
	assign result.entry_index   = res_s2.entry_index;
	assign result.field_done    = res_s2.field_done;
	assign result.field_value   = res_s2.field_value;
	assign result.tx_done       = res_s2.tx_done;
	assign result.overflow      = res_s2.overflow;

	`TRSP_ASSERT_NOW(a_full_stall, valid_s1 && valid_s2 && !result.ready, !stream.ready,
		"input taken while both stages are blocked")
	`TRSP_ASSERT_NEXT(a_step_lands, adv, valid_s2, "stepped byte did not reach result stage")
	`TRSP_ASSERT_NOW(a_tx_end, valid_s2 && res_s2.tx_done,
		res_s2.field_done && res_s2.field_kind == K_LOCK, "end of transaction off lock time")
	`TRSP_ASSERT_NOW(a_ovf_count, valid_s2 && res_s2.overflow,
		res_s2.field_done && (res_s2.field_kind == K_INCNT || res_s2.field_kind == K_INSLEN ||
		res_s2.field_kind == K_OUTCNT || res_s2.field_kind == K_OUTSLEN),
		"overflow outside a completed count or length")
	`TRSP_ASSERT_NOW(a_value_done, valid_s2 && !res_s2.field_done, res_s2.field_value == '0,
		"field value shown before field completes")

endmodule

// File: tb/sv/tb_tx_record_stream_parser_top.sv
// Self-checking testbench for tx_record_stream_parser_top: byte stream in, tagged bytes out.
module tb_tx_record_stream_parser_top;
	import trsp_pkg::*;

	// Largest count the parser can hold; anything above it saturates and is flagged.
	localparam logic [63:0] COUNT_MAX = (COUNT_W >= 64) ? '1 : ((64'd1 << COUNT_W) - 64'd1);
	// Eight-byte varint prefix; the two narrower ones come from the package.
	localparam logic [7:0] PFX_U64 = 8'hFF;
	localparam int RANDOM_ITEMS = 1100;
	localparam int DRAIN_LIMIT = 4000;

	typedef enum int {VI_BYTE, VI_U16, VI_U32, VI_U64} varint_form_t;

	logic clk = 1'b0;
	logic arst_n;

	trsp_in_if  byte_ch ();
	trsp_out_if tag_ch ();

	tx_record_stream_parser_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (byte_ch),
		.result (tag_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Tag predictor state: where in the transaction the next byte lands.
	kind_t       parse_phase;
	logic [31:0] field_ofs;
	logic [63:0] value_acc;
	logic [3:0]  prefix_left;
	logic [63:0] entries_pending;
	logic [63:0] entry_no;
	logic [63:0] script_left;

	// Tags predicted for accepted bytes, oldest first.
	result_t tags_due[$];
	// Bytes of the transaction being built for sending.
	logic [7:0] tx_bytes[$];

	bit failed = 1'b0;
	int bytes_sent = 0;
	int send_calm = 0;
	int take_calm = 0;

	// ---------------------------------------------------------------- predictor

	function automatic void clear_parse();
		parse_phase = K_VER;
		field_ofs = '0;
		value_acc = '0;
		prefix_left = '0;
		entries_pending = '0;
		entry_no = '0;
		script_left = '0;
	endfunction

	function automatic void enter_field(input kind_t kind);
		parse_phase = kind;
		field_ofs = '0;
		value_acc = '0;
		prefix_left = '0;
	endfunction

	// Close one input or output entry; leave the list once the last one is done.
	function automatic void close_entry(input kind_t next_kind, input kind_t after_last);
		if (entries_pending > 0)
			entries_pending--;
		entry_no = (entry_no + 64'd1) & COUNT_MAX;
		if (entries_pending == 0) begin
			entry_no = '0;
			enter_field(after_last);
		end else begin
			enter_field(next_kind);
		end
	endfunction

	// Work out the tag for one accepted byte and advance the parse state.
	function automatic result_t tag_byte(input logic [7:0] b, input logic rs);
		result_t r;
		logic [5:0] flen;
		logic [31:0] prev_ofs;
		logic [63:0] v;
		logic [63:0] c;
		logic whole;
		r = '0;
		if (rs || parse_phase > K_LOCK)
			clear_parse();
		r.byte_out = b;
		r.field_kind = parse_phase;
		r.byte_position = field_ofs;
		if ((parse_phase >= K_TXID && parse_phase <= K_SEQ) ||
				(parse_phase >= K_VALUE && parse_phase <= K_OUTSCR))
			r.entry_index = entry_no[31:0];

		case (parse_phase)
			K_VER, K_TXID, K_OUTIDX, K_SEQ, K_VALUE, K_LOCK: begin
				flen = (parse_phase == K_TXID) ? TXID_LEN :
					(parse_phase == K_VALUE) ? VALUE_LEN : WORD_LEN;
				if (field_ofs < 32'd8)
					value_acc |= {56'd0, b} << {field_ofs[2:0], 3'b000};
				field_ofs++;
				if (field_ofs >= 32'(flen)) begin
					r.field_done = 1'b1;
					r.field_value = (r.field_kind == K_TXID) ? 64'd0 : value_acc;
					case (r.field_kind)
						K_VER:    enter_field(K_INCNT);
						K_TXID:   enter_field(K_OUTIDX);
						K_OUTIDX: enter_field(K_INSLEN);
						K_SEQ:    close_entry(K_TXID, K_OUTCNT);
						K_VALUE:  enter_field(K_OUTSLEN);
						default: begin
							r.tx_done = 1'b1;
							clear_parse();
						end
					endcase
				end
			end
			K_INCNT, K_INSLEN, K_OUTCNT, K_OUTSLEN: begin
				whole = 1'b0;
				v = '0;
				if (field_ofs == 0) begin
					if (b < PFX_U16) begin
						v = {56'd0, b};
						whole = 1'b1;
					end else begin
						prefix_left = (b == PFX_U16) ? VAR_LEN_U16 :
							(b == PFX_U32) ? VAR_LEN_U32 : VAR_LEN_U64;
						value_acc = '0;
						field_ofs = 32'd1;
					end
				end else begin
					prev_ofs = field_ofs - 32'd1;
					value_acc |= {56'd0, b} << {prev_ofs[2:0], 3'b000};
					field_ofs++;
					if (prefix_left > 0)
						prefix_left--;
					if (prefix_left == 0) begin
						v = value_acc;
						whole = 1'b1;
					end
				end
				if (whole) begin
					r.field_done = 1'b1;
					r.field_value = v;
					c = v;
					if (v > COUNT_MAX) begin
						r.overflow = 1'b1;
						c = COUNT_MAX;
					end
					case (r.field_kind)
						K_INCNT: begin
							if (c == 0) begin
								enter_field(K_OUTCNT);
							end else begin
								entries_pending = c;
								entry_no = '0;
								enter_field(K_TXID);
							end
						end
						K_INSLEN: begin
							if (c == 0) begin
								enter_field(K_SEQ);
							end else begin
								script_left = c;
								enter_field(K_INSCR);
							end
						end
						K_OUTCNT: begin
							if (c == 0) begin
								enter_field(K_LOCK);
							end else begin
								entries_pending = c;
								entry_no = '0;
								enter_field(K_VALUE);
							end
						end
						default: begin
							if (c == 0) begin
								close_entry(K_VALUE, K_LOCK);
							end else begin
								script_left = c;
								enter_field(K_OUTSCR);
							end
						end
					endcase
				end
			end
			default: begin
				// script bytes: count down the declared length
				field_ofs++;
				if (script_left > 0)
					script_left--;
				if (script_left == 0) begin
					r.field_done = 1'b1;
					if (r.field_kind == K_INSCR)
						enter_field(K_SEQ);
					else
						close_entry(K_VALUE, K_LOCK);
				end
			end
		endcase
		return r;
	endfunction

	// ---------------------------------------------------------------- stream builder

	// Append one byte to the transaction under construction.
	function automatic void add_byte(input logic [7:0] b);
		tx_bytes.insert(tx_bytes.size(), b);
	endfunction

	function automatic void push_le(input logic [63:0] v, input int n);
		for (int i = 0; i < n; i++)
			add_byte(v[8*i +: 8]);
	endfunction

	function automatic void push_random(input int n);
		repeat (n) add_byte(8'($urandom));
	endfunction

	// Encode a compact-size value, now and then wider than it needs to be.
	function automatic void push_varint(input logic [63:0] v);
		varint_form_t narrowest;
		varint_form_t form;
		narrowest = (v < 64'hFD) ? VI_BYTE : (v <= 64'hFFFF) ? VI_U16 :
			(v <= 64'hFFFF_FFFF) ? VI_U32 : VI_U64;
		form = narrowest;
		if ($urandom_range(0, 4) == 0)
			form = varint_form_t'($urandom_range(int'(narrowest), int'(VI_U64)));
		case (form)
			VI_BYTE: add_byte(v[7:0]);
			VI_U16: begin
				add_byte(PFX_U16);
				push_le(v, 2);
			end
			VI_U32: begin
				add_byte(PFX_U32);
				push_le(v, 4);
			end
			default: begin
				add_byte(PFX_U64);
				push_le(v, 8);
			end
		endcase
	endfunction

	// Push a count or length; rarely swap in a huge one around the saturation point.
	// Returns 1 when the transaction can no longer be finished sensibly.
	function automatic bit push_length(input int n);
		logic [63:0] v;
		if ($urandom_range(0, 39) != 0) begin
			push_varint(64'(n));
			return 1'b0;
		end
		case ($urandom_range(0, 3))
			0: v = COUNT_MAX;
			1: v = COUNT_MAX + 64'd1;
			2: v = {32'($urandom_range(1, 32'hFFFF_FFFF)), 32'($urandom)};
			default: v = {32'd0, 32'($urandom)};
		endcase
		push_varint(v);
		return 1'b1;
	endfunction

	function automatic int draw_entries();
		case ($urandom_range(0, 5))
			0: return 0;
			4: return 2;
			5: return 3;
			default: return 1;
		endcase
	endfunction

	function automatic int draw_script_len();
		case ($urandom_range(0, 19))
			0: return 0;
			1: return $urandom_range(253, 300);
			default: return $urandom_range(1, 24);
		endcase
	endfunction

	// Build one legacy transaction with random content; 1 when it was cut short.
	function automatic bit build_tx();
		int n_in;
		int n_out;
		int slen;
		tx_bytes.delete();
		push_le(64'($urandom), 4);
		n_in = draw_entries();
		if (push_length(n_in))
			return 1'b1;
		for (int i = 0; i < n_in; i++) begin
			push_random(32);
			push_le(64'($urandom), 4);
			slen = draw_script_len();
			if (push_length(slen))
				return 1'b1;
			push_random(slen);
			push_le(64'($urandom), 4);
		end
		n_out = draw_entries();
		if (push_length(n_out))
			return 1'b1;
		for (int i = 0; i < n_out; i++) begin
			push_le({32'($urandom), 32'($urandom)}, 8);
			slen = draw_script_len();
			if (push_length(slen))
				return 1'b1;
			push_random(slen);
		end
		push_le(64'($urandom), 4);
		return 1'b0;
	endfunction

	// ---------------------------------------------------------------- handshakes

	// Idle cycles before the next item; now and then a calm stretch with none at all.
	function automatic int draw_wait(inout int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 23) == 0) begin
			calm_left = $urandom_range(8, 48);
			return 0;
		end
		return $urandom_range(0, 14);
	endfunction

	// Offer one byte and hold it until taken; predict its tag on acceptance.
	// Leave valid high afterwards so back-to-back items need no drop.
	task automatic send_byte(input logic [7:0] b, input logic rs);
		int idle;
		idle = draw_wait(send_calm);
		if (idle > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= b;
		byte_ch.restart <= rs;
		do @(posedge clk); while (!byte_ch.ready);
		tags_due.insert(tags_due.size(), tag_byte(b, rs));
		bytes_sent++;
	endtask

	task automatic send_queue(input bit lead_restart, input int upto);
		for (int i = 0; i < upto; i++)
			send_byte(tx_bytes[i], (i == 0) ? lead_restart : 1'b0);
	endtask

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			failed = 1'b1;
		end
	endfunction

	// Take result items with random stalls and compare each with the oldest prediction.
	initial begin
		result_t got;
		result_t want;
		int idle;
		tag_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			idle = draw_wait(take_calm);
			if (idle > 0) begin
				tag_ch.ready <= 1'b0;
				repeat (idle) @(posedge clk);
			end
			tag_ch.ready <= 1'b1;
			do @(posedge clk); while (tag_ch.valid !== 1'b1);
			got.byte_out = tag_ch.byte_out;
			got.field_kind = kind_t'(tag_ch.field_kind);
			got.byte_position = tag_ch.byte_position;
			got.entry_index = tag_ch.entry_index;
			got.field_done = tag_ch.field_done;
			got.field_value = tag_ch.field_value;
			got.tx_done = tag_ch.tx_done;
			got.overflow = tag_ch.overflow;
			if (tags_due.size() == 0) begin
				$error("result item with no byte awaiting a tag: byte_out 0x%0h", got.byte_out);
				failed = 1'b1;
			end else begin
				want = tags_due.pop_front();
				check_field("byte_out", 64'(want.byte_out), 64'(got.byte_out));
				check_field("field_kind", 64'(want.field_kind), 64'(tag_ch.field_kind));
				check_field("byte_position", 64'(want.byte_position), 64'(got.byte_position));
				check_field("entry_index", 64'(want.entry_index), 64'(got.entry_index));
				check_field("field_done", 64'(want.field_done), 64'(got.field_done));
				check_field("field_value", want.field_value, got.field_value);
				check_field("tx_done", 64'(want.tx_done), 64'(got.tx_done));
				check_field("overflow", 64'(want.overflow), 64'(got.overflow));
			end
		end
	end

	// ---------------------------------------------------------------- tests

	// Smallest transaction: no inputs, no outputs, all-ones version, zero lock time.
	task automatic test_empty_transaction();
		tx_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		send_queue(1'b1, tx_bytes.size());
	endtask

	// Zero counts written with wide prefixes; follows straight on from the previous
	// transaction without a restart, so the end-of-transaction return is exercised.
	task automatic test_prefixed_zero_counts();
		tx_bytes = '{8'h01, 8'h00, 8'h00, 8'h00,
			PFX_U16, 8'h00, 8'h00,
			PFX_U32, 8'h00, 8'h00, 8'h00, 8'h00,
			8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_queue(1'b0, tx_bytes.size());
	endtask

	// Abandon a version field part way; the next byte arrives with restart set.
	task automatic test_restart_mid_field();
		tx_bytes = '{8'h12, 8'h34, 8'h56};
		send_queue(1'b0, tx_bytes.size());
	endtask

	// Mostly well-formed transactions with random content, some truncated, some
	// with huge counts, and now and then plain noise with scattered restarts.
	task automatic test_random_streams();
		int first;
		int upto;
		bit cut;
		bit lead;
		first = bytes_sent;
		lead = 1'b1;
		while (bytes_sent - first < RANDOM_ITEMS) begin
			if ($urandom_range(0, 19) == 0) begin
				tx_bytes.delete();
				push_random($urandom_range(4, 30));
				foreach (tx_bytes[i])
					send_byte(tx_bytes[i], (i == 0) ? lead : ($urandom_range(0, 9) == 0));
				lead = 1'b1;
			end else begin
				cut = build_tx();
				// run on past a huge count into whatever field it leads to
				if (cut)
					push_random($urandom_range(0, 40));
				upto = tx_bytes.size();
				if (!cut && $urandom_range(0, 7) == 0) begin
					upto = $urandom_range(1, upto - 1);
					cut = 1'b1;
				end
				send_queue(lead || ($urandom_range(0, 1) == 1), upto);
				lead = cut;
			end
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		int spin;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = 8'h00;
		byte_ch.restart = 1'b0;
		arst_n = 1'b0;
		clear_parse();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_transaction();
		test_prefixed_zero_counts();
		test_restart_mid_field();
		test_random_streams();

		byte_ch.valid <= 1'b0;
		// drain the pipe, then keep watching for any stray item before the final check
		for (spin = 0; spin < DRAIN_LIMIT && tags_due.size() != 0; spin++)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (tags_due.size() != 0) begin
			$error("%0d predicted tags never arrived", tags_due.size());
			failed = 1'b1;
		end
		if (!failed) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Hang guard: far beyond the slowest correct run.
	initial begin
		#800000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
